@@ hw/rtl/hfd_pkg.sv @@
// Package for the humidity/temperature frame decoder.
// Holds byte position codes, CRC-8 constants and fold function, scaling constants
// and the frame type. No dependencies.
package hfd_pkg;

   localparam logic [2:0] POS_TEMP_MSB = 3'd0;
   localparam logic [2:0] POS_TEMP_LSB = 3'd1;
   localparam logic [2:0] POS_TEMP_CRC = 3'd2;
   localparam logic [2:0] POS_HUM_MSB  = 3'd3;
   localparam logic [2:0] POS_HUM_LSB  = 3'd4;
   localparam logic [2:0] POS_HUM_CRC  = 3'd5;

   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_POLY = 8'h31;

   localparam logic [14:0] TEMP_SPAN   = 15'd17500;
   localparam logic [15:0] TEMP_OFFSET = 16'd4500;
   localparam logic [13:0] HUM_SPAN    = 14'd12500;
   localparam logic [13:0] HUM_OFFSET  = 14'd600;
   localparam logic [13:0] HUM_MAX     = 14'd10000;
   localparam logic [13:0] HUM_TOP_RAW = 14'd10600;

   typedef struct packed {
      logic [15:0] temp_word;
      logic [15:0] hum_word;
      logic        crc_ok;
   } frame_type;

   // CRC-8, MSB first, one byte folded into the running value
   function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] v;
      v = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
      end
      return v;
   endfunction

endpackage

@@ hw/rtl/hfd_if.sv @@
// Valid/ready channel interfaces of the frame decoder.
// Depends on nothing; used by all modules.
interface hfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_start;
   modport source(output valid, data_byte, frame_start, input ready);
   modport sink(input valid, data_byte, frame_start, output ready);
endinterface

interface hfd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [14:0] temperature_centi;
   logic        [13:0] humidity_centi;
   logic               reading_valid;
   modport source(output valid, temperature_centi, humidity_centi, reading_valid, input ready);
   modport sink(input valid, temperature_centi, humidity_centi, reading_valid, output ready);
endinterface

@@ hw/rtl/hfd_assembler.sv @@
// Byte tracking, running CRC check and word capture for the frame decoder.
// Depends on hfd_pkg and hfd_req_if; hands a finished frame on through a register.
module hfd_assembler (
   input  logic               clock,
   input  logic               reset,
   hfd_req_if.sink            req_ch,
   output logic               frame_valid,
   output hfd_pkg::frame_type frame,
   input  logic               frame_ready
);

   logic [2:0]         pos_ff, pos_in;
   logic [7:0]         crc_ff, crc_in;
   logic [15:0]        temp_word_ff, temp_word_in;
   logic [15:0]        hum_word_ff, hum_word_in;
   logic               temp_ok_ff, temp_ok_in;
   logic               frame_valid_ff, frame_valid_in;
   hfd_pkg::frame_type frame_ff, frame_in;

   logic       accept;
   logic [2:0] pos_eff;
   logic [7:0] base;
   logic [7:0] fold;

   assign req_ch.ready = !frame_valid_ff || frame_ready;
   assign accept       = req_ch.valid && req_ch.ready;

   assign pos_eff = (req_ch.frame_start || pos_ff > hfd_pkg::POS_HUM_CRC) ?
                    hfd_pkg::POS_TEMP_MSB : pos_ff;
   assign base    = (pos_eff == hfd_pkg::POS_TEMP_MSB || pos_eff == hfd_pkg::POS_HUM_MSB) ?
                    hfd_pkg::CRC_INIT : crc_ff;
   assign fold    = hfd_pkg::crc_fold(base, req_ch.data_byte);

   always_comb begin
      pos_in       = pos_ff;
      crc_in       = crc_ff;
      temp_word_in = temp_word_ff;
      hum_word_in  = hum_word_ff;
      temp_ok_in   = temp_ok_ff;
      if (accept) begin
         pos_in = pos_eff + 3'd1;
         unique case (pos_eff)
            hfd_pkg::POS_TEMP_MSB: begin
               temp_word_in[15:8] = req_ch.data_byte;
               crc_in             = fold;
            end
            hfd_pkg::POS_TEMP_LSB: begin
               temp_word_in[7:0] = req_ch.data_byte;
               crc_in            = fold;
            end
            hfd_pkg::POS_TEMP_CRC: begin
               temp_ok_in = (base == req_ch.data_byte);
               crc_in     = hfd_pkg::CRC_INIT;
            end
            hfd_pkg::POS_HUM_MSB: begin
               hum_word_in[15:8] = req_ch.data_byte;
               crc_in            = fold;
            end
            hfd_pkg::POS_HUM_LSB: begin
               hum_word_in[7:0] = req_ch.data_byte;
               crc_in           = fold;
            end
            default: begin
               crc_in = hfd_pkg::CRC_INIT;
               pos_in = hfd_pkg::POS_TEMP_MSB;
            end
         endcase
      end
   end

   always_comb begin
      frame_in.temp_word = temp_word_ff;
      frame_in.hum_word  = hum_word_ff;
      frame_in.crc_ok    = temp_ok_ff && (base == req_ch.data_byte);
      if (accept && pos_eff == hfd_pkg::POS_HUM_CRC) begin
         frame_valid_in = 1'b1;
      end else if (frame_ready) begin
         frame_valid_in = 1'b0;
      end else begin
         frame_valid_in = frame_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= hfd_pkg::POS_TEMP_MSB;
         crc_ff         <= hfd_pkg::CRC_INIT;
         temp_ok_ff     <= 1'b0;
         frame_valid_ff <= 1'b0;
      end else begin
         pos_ff         <= pos_in;
         crc_ff         <= crc_in;
         temp_ok_ff     <= temp_ok_in;
         frame_valid_ff <= frame_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      temp_word_ff <= temp_word_in;
      hum_word_ff  <= hum_word_in;
      if (accept && pos_eff == hfd_pkg::POS_HUM_CRC) begin
         frame_ff <= frame_in;
      end
   end

   assign frame_valid = frame_valid_ff;
   assign frame       = frame_ff;

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= hfd_pkg::POS_HUM_CRC)
      else $error("byte position out of range");

   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      accept && pos_eff == hfd_pkg::POS_HUM_CRC |=>
         pos_ff == hfd_pkg::POS_TEMP_MSB && crc_ff == hfd_pkg::CRC_INIT && frame_valid_ff)
      else $error("frame end did not restart position or post frame");

   a_frame_hold: assert property (@(posedge clock) disable iff (reset)
      frame_valid_ff && !frame_ready |=> frame_valid_ff && $stable(frame_ff))
      else $error("stalled frame changed");

endmodule

@@ hw/rtl/hfd_scaler.sv @@
// Scales the checked words to centi-degrees and centi-percent.
// Depends on hfd_pkg and hfd_rsp_if. Multiply stage, then divide-by-65535,
// offset and clamp into the result register.
module hfd_scaler (
   input  logic               clock,
   input  logic               reset,
   input  logic               frame_valid,
   input  hfd_pkg::frame_type frame,
   output logic               frame_ready,
   hfd_rsp_if.source          rsp_ch
);

   logic [30:0] prod_t_ff;
   logic [29:0] prod_h_ff;
   logic        prod_ok_ff;
   logic        prod_valid_ff, prod_valid_in;

   logic               out_valid_ff, out_valid_in;
   logic signed [14:0] temp_ff, temp_in;
   logic        [13:0] hum_ff, hum_in;
   logic               ok_ff;

   logic        prod_adv, out_adv;
   logic [31:0] sum_t;
   logic [30:0] sum_h;
   logic [14:0] q_t;
   logic [13:0] q_h;
   logic [15:0] t_diff;

   assign out_adv     = !out_valid_ff || rsp_ch.ready;
   assign prod_adv    = !prod_valid_ff || out_adv;
   assign frame_ready = prod_adv;

   assign prod_valid_in = prod_adv ? frame_valid : prod_valid_ff;
   assign out_valid_in  = out_adv ? prod_valid_ff : out_valid_ff;

   // floor(x / 65535) = (x + (x >> 16) + 1) >> 16 for quotients below 65536
   assign sum_t  = 32'(prod_t_ff) + 32'(prod_t_ff[30:16]) + 32'd1;
   assign sum_h  = 31'(prod_h_ff) + 31'(prod_h_ff[29:16]) + 31'd1;
   assign q_t    = sum_t[30:16];
   assign q_h    = sum_h[29:16];
   assign t_diff = 16'(q_t) - hfd_pkg::TEMP_OFFSET;

   always_comb begin
      temp_in = '0;
      hum_in  = '0;
      if (prod_ok_ff) begin
         temp_in = t_diff[14:0];
         if (q_h < hfd_pkg::HUM_OFFSET) begin
            hum_in = '0;
         end else if (q_h > hfd_pkg::HUM_TOP_RAW) begin
            hum_in = hfd_pkg::HUM_MAX;
         end else begin
            hum_in = q_h - hfd_pkg::HUM_OFFSET;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (prod_adv && frame_valid) begin
         prod_t_ff  <= 31'(hfd_pkg::TEMP_SPAN) * 31'(frame.temp_word);
         prod_h_ff  <= 30'(hfd_pkg::HUM_SPAN) * 30'(frame.hum_word);
         prod_ok_ff <= frame.crc_ok;
      end
      if (out_adv && prod_valid_ff) begin
         temp_ff <= temp_in;
         hum_ff  <= hum_in;
         ok_ff   <= prod_ok_ff;
      end
   end

   assign rsp_ch.valid             = out_valid_ff;
   assign rsp_ch.temperature_centi = temp_ff;
   assign rsp_ch.humidity_centi    = hum_ff;
   assign rsp_ch.reading_valid     = ok_ff;

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !ok_ff |-> temp_ff == '0 && hum_ff == '0)
      else $error("failed reading carries nonzero values");

   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> hum_ff <= hfd_pkg::HUM_MAX)
      else $error("humidity above clamp");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      prod_valid_ff && !out_adv |=> prod_valid_ff && $stable(prod_t_ff))
      else $error("product stage lost an item under stall");

endmodule

@@ hw/rtl/humidity_temp_frame_decoder_unit.sv @@
// Humidity/temperature frame decoder, top level.
// The accepted sixth byte of a frame passes the frame, product and result
// registers. Throughput: one byte per cycle unless the output stalls; the CRC
// fold is combinational; multiply and divide-by-65535 are two pipeline stages.
// Reset (synchronous, active high): byte position 0, CRC 0xFF, pipeline empty.
// Depends on hfd_pkg, hfd_if, hfd_assembler and hfd_scaler.
module humidity_temp_frame_decoder_unit (
   input  logic        clock,
   input  logic        reset,
   hfd_req_if.sink     req_ch,
   hfd_rsp_if.source   rsp_ch
);

   logic               frame_valid;
   logic               frame_ready;
   hfd_pkg::frame_type frame;

   hfd_assembler u_assembler (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .frame_valid (frame_valid),
      .frame       (frame),
      .frame_ready (frame_ready)
   );

   hfd_scaler u_scaler (
      .clock       (clock),
      .reset       (reset),
      .frame_valid (frame_valid),
      .frame       (frame),
      .frame_ready (frame_ready),
      .rsp_ch      (rsp_ch)
   );

endmodule

@@ dv/humidity_temp_frame_decoder_unit_tb.sv @@
`timescale 1ns / 1ps
// Testbench for humidity_temp_frame_decoder_unit: byte frames in, scaled readings out,
// checked against a scoreboard class holding its own decoder state.
// Depends on hfd_pkg, hfd_if and the decoder RTL.

typedef struct {
   logic signed [14:0] temp;
   logic        [13:0] hum;
   logic               ok;
} reading_type;

function automatic logic [7:0] crc8_byte(input logic [7:0] c, input logic [7:0] b);
   logic [7:0] r;
   logic       fb;
   r = c;
   for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ b[i];
      r  = {r[6:0], 1'b0} ^ (fb ? hfd_pkg::CRC_POLY : 8'h00);
   end
   return r;
endfunction

class reading_predictor;
   logic [2:0]  position;
   logic [7:0]  crc;
   logic [15:0] temp_word;
   logic [15:0] hum_word;
   bit          temp_ok;
   reading_type expected_readings[$];
   int          errors;

   function new();
      position  = hfd_pkg::POS_TEMP_MSB;
      crc       = hfd_pkg::CRC_INIT;
      temp_word = '0;
      hum_word  = '0;
      temp_ok   = 1'b0;
      errors    = 0;
   endfunction

   function int pending();
      return expected_readings.size();
   endfunction

   function void note_byte(input logic [7:0] b, input logic start);
      logic [2:0]  pos;
      logic [7:0]  seed;
      reading_type rd;
      int          t;
      int          h;
      pos = start ? hfd_pkg::POS_TEMP_MSB : position;
      if (pos > hfd_pkg::POS_HUM_CRC) pos = hfd_pkg::POS_TEMP_MSB;
      seed = (pos == hfd_pkg::POS_TEMP_MSB || pos == hfd_pkg::POS_HUM_MSB) ?
             hfd_pkg::CRC_INIT : crc;
      case (pos)
         hfd_pkg::POS_TEMP_MSB: begin
            temp_word[15:8] = b;
            crc = crc8_byte(seed, b);
         end
         hfd_pkg::POS_TEMP_LSB: begin
            temp_word[7:0] = b;
            crc = crc8_byte(seed, b);
         end
         hfd_pkg::POS_TEMP_CRC: begin
            temp_ok = (seed == b);
            crc = hfd_pkg::CRC_INIT;
         end
         hfd_pkg::POS_HUM_MSB: begin
            hum_word[15:8] = b;
            crc = crc8_byte(seed, b);
         end
         hfd_pkg::POS_HUM_LSB: begin
            hum_word[7:0] = b;
            crc = crc8_byte(seed, b);
         end
         default: begin
            rd.ok = temp_ok && (seed == b);
            t = 0;
            h = 0;
            if (rd.ok) begin
               t = (17500 * int'(temp_word)) / 65535 - 4500;
               h = (12500 * int'(hum_word)) / 65535 - 600;
               if (h < 0) h = 0;
               if (h > 10000) h = 10000;
            end
            rd.temp = 15'(t);
            rd.hum  = 14'(h);
            expected_readings.push_back(rd);
            crc = hfd_pkg::CRC_INIT;
            position = hfd_pkg::POS_TEMP_MSB;
            return;
         end
      endcase
      position = pos + 3'd1;
   endfunction

   function void check_reading(input logic signed [14:0] temp, input logic [13:0] hum,
                               input logic ok);
      reading_type rd;
      if (expected_readings.size() == 0) begin
         $display("%0t: unexpected reading temp=%0d hum=%0d valid=%0b", $time, temp, hum, ok);
         errors++;
         return;
      end
      rd = expected_readings.pop_front();
      if (temp !== rd.temp) begin
         $display("%0t: temperature_centi expected %0d actual %0d", $time, rd.temp, temp);
         errors++;
      end
      if (hum !== rd.hum) begin
         $display("%0t: humidity_centi expected %0d actual %0d", $time, rd.hum, hum);
         errors++;
      end
      if (ok !== rd.ok) begin
         $display("%0t: reading_valid expected %0b actual %0b", $time, rd.ok, ok);
         errors++;
      end
   endfunction
endclass

module humidity_temp_frame_decoder_unit_tb;

   localparam int TOTAL_BYTES = 1300;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   send_idle = 9;
   int   recv_idle = 48;
   int   bytes_sent = 0;
   bit   force_start = 1'b0;

   reading_predictor sb = new();

   hfd_req_if req_ch ();
   hfd_rsp_if rsp_ch ();

   humidity_temp_frame_decoder_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_reading(rsp_ch.temperature_centi, rsp_ch.humidity_centi,
                             rsp_ch.reading_valid);
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic s);
      while ($urandom_range(99) < send_idle) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.data_byte   <= b;
      req_ch.frame_start <= s;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_byte(b, s);
      bytes_sent++;
   endtask

   task automatic send_frame(input logic [15:0] tw, input logic [15:0] hw, input logic start,
                             input bit bad_t, input bit bad_h, input int count);
      logic [7:0] bytes [6];
      bytes[0] = tw[15:8];
      bytes[1] = tw[7:0];
      bytes[2] = crc8_byte(crc8_byte(hfd_pkg::CRC_INIT, tw[15:8]), tw[7:0]);
      bytes[3] = hw[15:8];
      bytes[4] = hw[7:0];
      bytes[5] = crc8_byte(crc8_byte(hfd_pkg::CRC_INIT, hw[15:8]), hw[7:0]);
      if (bad_t) bytes[2] ^= 8'($urandom_range(1, 255));
      if (bad_h) bytes[5] ^= 8'($urandom_range(1, 255));
      for (int i = 0; i < count; i++)
         send_byte(bytes[i], (i == 0) ? start : 1'b0);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_word();
      case ($urandom_range(9))
         0:       return 16'(3140 + $urandom_range(12));
         1:       return 16'(55568 + $urandom_range(16));
         2:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      int kind;
      int n;
      req_ch.valid       <= 1'b0;
      req_ch.data_byte   <= 8'h00;
      req_ch.frame_start <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // extremes, clamps, bad CRCs and a restart mid-frame
      send_frame(16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0, 6);
      send_frame(16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0, 6);
      send_byte(8'hAB, 1'b1);
      send_byte(8'hCD, 1'b0);
      send_byte(8'h12, 1'b0);
      send_frame(16'h6666, 16'h8000, 1'b1, 1'b1, 1'b0, 6);
      send_frame(16'h1234, 16'h0C4A, 1'b0, 1'b0, 1'b1, 6);

      for (int phase = 0; phase < 3; phase++) begin
         drain();
         case (phase)
            0: begin send_idle = 9;  recv_idle = 48; end
            1: begin send_idle = 48; recv_idle = 9;  end
            default: begin send_idle = 0; recv_idle = 0; end
         endcase
         while (bytes_sent < 27 + (phase + 1) * ((TOTAL_BYTES - 27) / 3)) begin
            kind = $urandom_range(99);
            if (kind < 75) begin
               send_frame(pick_word(), pick_word(), force_start | 1'($urandom_range(1)),
                          ($urandom_range(9) == 0), ($urandom_range(9) == 0), 6);
               force_start = 1'b0;
            end else if (kind < 90) begin
               send_frame(pick_word(), pick_word(), 1'($urandom_range(1)), 1'b0, 1'b0,
                          $urandom_range(1, 5));
               force_start = 1'b1;
            end else begin
               n = $urandom_range(1, 4);
               repeat (n) send_byte(8'($urandom), 1'($urandom_range(1)));
            end
         end
      end

      drain();
      repeat (10) @(posedge clock);
      if (sb.errors == 0)
         $display("humidity_temp_frame_decoder_unit verification clean");
      else
         $display("humidity_temp_frame_decoder_unit verification failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("humidity_temp_frame_decoder_unit verification failed");
      $finish;
   end

endmodule
